### rtl/core/tbr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tbr_pkg;

  localparam int TILE_WIDTH = 256;
  localparam int GRID_COLS  = 256;
  localparam int GRID_ROWS  = 256;
  localparam int TABLE_LEN  = TILE_WIDTH + 2;

  localparam int POS_W    = 9;
  localparam int IDX_W    = 8;
  localparam int FRAC_W   = 16;
  localparam int SAMPLE_W = 16;
  localparam int ENTRY_W  = IDX_W + FRAC_W;

  localparam int NUM_BANKS  = 4;
  localparam int BANK_DEPTH = GRID_COLS * GRID_ROWS / NUM_BANKS;
  localparam int BANK_AW    = $clog2(BANK_DEPTH);

  localparam logic [POS_W-1:0] LAST_ENTRY = POS_W'(TILE_WIDTH + 1);
  localparam logic [POS_W-1:0] COL_COUNT  = POS_W'(GRID_COLS);
  localparam logic [POS_W-1:0] ROW_COUNT  = POS_W'(GRID_ROWS);
  localparam logic [IDX_W-1:0] COL_LIMIT  = IDX_W'(GRID_COLS - 2);
  localparam logic [IDX_W-1:0] ROW_LIMIT  = IDX_W'(GRID_ROWS - 2);

  localparam logic [1:0] KIND_GRID_WR = 2'd0;
  localparam logic [1:0] KIND_COL_WR  = 2'd1;
  localparam logic [1:0] KIND_ROW_WR  = 2'd2;
  localparam logic [1:0] KIND_QUERY   = 2'd3;

  typedef struct packed {
    logic [1:0]                 kind;
    logic [POS_W-1:0]           x_pos;
    logic [POS_W-1:0]           y_pos;
    logic signed [SAMPLE_W-1:0] sample;
    logic [IDX_W-1:0]           cell_index;
    logic [FRAC_W-1:0]          cell_fraction;
  } req_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic [POS_W-1:0]           pixel_x;
    logic [POS_W-1:0]           pixel_y;
  } rsp_t;

  function automatic logic [POS_W-1:0] entry_of(input logic [POS_W-1:0] p);
    entry_of = (p == '0) ? LAST_ENTRY : p - 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] clamp_idx(input logic [IDX_W-1:0] idx,
                                                 input logic [IDX_W-1:0] lim);
    clamp_idx = (idx > lim) ? lim : idx;
  endfunction

endpackage
`default_nettype wire

### rtl/core/tile_bilinear_resampler_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Bilinear resampler of a 256x256 grid of signed 16-bit samples onto a tile.
// Request channel (req_valid/req_ready/req): one item per cycle unless stalled;
// kind selects grid sample write, column or row table write, or pixel query.
// Response channel (rsp_valid/rsp_ready/rsp): one item per in-range query,
// in request order; writes and out-of-range queries give no item.
// Throughput: 1 item per cycle unless stalled. The grid sits in four parity
// banks (row LSB, column LSB), so the four neighbors of a query come out of one
// read of each bank; each table has one write and one read port, read in the
// accept cycle.
// Pipeline: table read, bank read, difference, multiply, add, for x, then
// difference, multiply, add for y into the output register.
// Stall: each stage advances whenever the stage after it is empty or moving,
// so bubbles collapse and req_ready stays high until all stages hold items
// behind a stalled output. Grid writes are applied as they leave stage 1,
// after every earlier query has read its samples.
// Reset: clears the pipeline valid bits only. Grid and table contents are
// undefined until written; there is no clearing pass.
module tile_bilinear_resampler_top (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire tbr_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output tbr_pkg::rsp_t      rsp
);
  import tbr_pkg::*;

  logic acc;
  logic en1, en2, en3, en4, en5, en6, en7, en8;
  logic v1, v2, v3, v4, v5, v6, v7;
  logic q1;
  logic req_query_ok, req_grid_ok;

  logic [ENTRY_W-1:0] col_mem [TABLE_LEN];
  logic [ENTRY_W-1:0] row_mem [TABLE_LEN];
  logic [ENTRY_W-1:0] col_rd, row_rd;

  logic [POS_W-1:0] x1, y1, x2, y2, x3, y3, x4, y4, x5, y5, x6, y6, x7, y7;
  logic signed [SAMPLE_W-1:0] sample1;

  logic [IDX_W-1:0]  ci, ri;
  logic              gw_en;
  logic [1:0]        gw_bank;
  logic [BANK_AW-1:0] gw_addr;
  logic signed [SAMPLE_W-1:0] bank_rd [NUM_BANKS];

  logic              ci0, ri0;
  logic [FRAC_W-1:0] ct2, rt2, ct3, rt3, rt4, rt5, rt6;
  logic signed [SAMPLE_W-1:0] ul, ur, bl, br;
  logic signed [SAMPLE_W-1:0] ul3, bl3, ul4, bl4, top5, bot5, top6, top7;
  logic signed [SAMPLE_W:0]   dt3, db3, dy6;
  logic signed [2*SAMPLE_W+1:0] pt4, pb4, py7;
  logic signed [SAMPLE_W:0]   top_sum, bot_sum, val_sum;

  // handshake and stage enables
  assign en8       = !rsp_valid || rsp_ready;
  assign en7       = !v7 || en8;
  assign en6       = !v6 || en7;
  assign en5       = !v5 || en6;
  assign en4       = !v4 || en5;
  assign en3       = !v3 || en4;
  assign en2       = !v2 || en3;
  assign en1       = !v1 || en2;
  assign req_ready = en1;
  assign acc       = req_valid && req_ready;

  assign req_query_ok = (req.kind == KIND_QUERY) && (req.x_pos <= LAST_ENTRY) &&
                        (req.y_pos <= LAST_ENTRY);
  assign req_grid_ok  = (req.kind == KIND_GRID_WR) && (req.x_pos < COL_COUNT) &&
                        (req.y_pos < ROW_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (en1) v1 <= acc && (req_query_ok || req_grid_ok);
      if (en2) v2 <= v1 && q1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
      if (en6) v6 <= v5;
      if (en7) v7 <= v6;
      if (en8) rsp_valid <= v7;
    end
  end

  // coordinate tables
  always_ff @(posedge clk) begin
    if (acc && req.kind == KIND_COL_WR && req.x_pos <= LAST_ENTRY) begin
      col_mem[req.x_pos] <= {clamp_idx(req.cell_index, COL_LIMIT), req.cell_fraction};
    end
    if (acc && req.kind == KIND_ROW_WR && req.y_pos <= LAST_ENTRY) begin
      row_mem[req.y_pos] <= {clamp_idx(req.cell_index, ROW_LIMIT), req.cell_fraction};
    end
    if (en1) begin
      col_rd <= col_mem[entry_of(req.x_pos)];
      row_rd <= row_mem[entry_of(req.y_pos)];
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      q1      <= (req.kind == KIND_QUERY);
      x1      <= req.x_pos;
      y1      <= req.y_pos;
      sample1 <= req.sample;
    end
  end

  // grid banks, selected by row and column parity
  assign ci      = col_rd[ENTRY_W-1:FRAC_W];
  assign ri      = row_rd[ENTRY_W-1:FRAC_W];
  assign gw_en   = v1 && !q1 && en1;
  assign gw_bank = {y1[0], x1[0]};
  assign gw_addr = {y1[IDX_W-1:1], x1[IDX_W-1:1]};

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    localparam logic CP = 1'(b % 2);
    localparam logic RP = 1'(b / 2);
    logic signed [SAMPLE_W-1:0] mem [BANK_DEPTH];
    logic signed [SAMPLE_W-1:0] rd;
    logic [IDX_W-1:0]   rc, rr;
    logic [BANK_AW-1:0] raddr;

    always_comb begin
      rc    = (ci[0] == CP) ? ci : ci + 1'b1;
      rr    = (ri[0] == RP) ? ri : ri + 1'b1;
      raddr = {rr[IDX_W-1:1], rc[IDX_W-1:1]};
    end

    always_ff @(posedge clk) begin
      if (gw_en && gw_bank == 2'(b)) mem[gw_addr] <= sample1;
      if (en2) rd <= mem[raddr];
    end

    assign bank_rd[b] = rd;
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      ci0 <= ci[0];
      ri0 <= ri[0];
      ct2 <= col_rd[FRAC_W-1:0];
      rt2 <= row_rd[FRAC_W-1:0];
      x2  <= x1;
      y2  <= y1;
    end
  end

  assign ul = bank_rd[{ri0, ci0}];
  assign ur = bank_rd[{ri0, !ci0}];
  assign bl = bank_rd[{!ri0, ci0}];
  assign br = bank_rd[{!ri0, !ci0}];

  // x lerp
  always_ff @(posedge clk) begin
    if (en3) begin
      ul3 <= ul;
      bl3 <= bl;
      dt3 <= {ur[SAMPLE_W-1], ur} - {ul[SAMPLE_W-1], ul};
      db3 <= {br[SAMPLE_W-1], br} - {bl[SAMPLE_W-1], bl};
      ct3 <= ct2;
      rt3 <= rt2;
      x3  <= x2;
      y3  <= y2;
    end
    if (en4) begin
      ul4 <= ul3;
      bl4 <= bl3;
      pt4 <= dt3 * $signed({1'b0, ct3});
      pb4 <= db3 * $signed({1'b0, ct3});
      rt4 <= rt3;
      x4  <= x3;
      y4  <= y3;
    end
  end

  assign top_sum = {ul4[SAMPLE_W-1], ul4} + pt4[2*SAMPLE_W:SAMPLE_W];
  assign bot_sum = {bl4[SAMPLE_W-1], bl4} + pb4[2*SAMPLE_W:SAMPLE_W];

  // y lerp
  always_ff @(posedge clk) begin
    if (en5) begin
      top5 <= top_sum[SAMPLE_W-1:0];
      bot5 <= bot_sum[SAMPLE_W-1:0];
      rt5  <= rt4;
      x5   <= x4;
      y5   <= y4;
    end
    if (en6) begin
      top6 <= top5;
      dy6  <= {bot5[SAMPLE_W-1], bot5} - {top5[SAMPLE_W-1], top5};
      rt6  <= rt5;
      x6   <= x5;
      y6   <= y5;
    end
    if (en7) begin
      top7 <= top6;
      py7  <= dy6 * $signed({1'b0, rt6});
      x7   <= x6;
      y7   <= y6;
    end
  end

  assign val_sum = {top7[SAMPLE_W-1], top7} + py7[2*SAMPLE_W:SAMPLE_W];

  always_ff @(posedge clk) begin
    if (en8) begin
      rsp.value   <= val_sum[SAMPLE_W-1:0];
      rsp.pixel_x <= x7;
      rsp.pixel_y <= y7;
    end
  end

  a_full_stall : assert property (@(posedge clk) disable iff (rst)
    (v1 && v2 && v3 && v4 && v5 && v6 && v7 && rsp_valid && !rsp_ready) |-> !req_ready)
    else $error("request accepted while pipeline full and stalled");

  a_rsp_source : assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(v7))
    else $error("response without a query in the last stage");

  a_bad_query_drop : assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && req.kind == KIND_QUERY &&
     (req.x_pos > LAST_ENTRY || req.y_pos > LAST_ENTRY)) |=> !v1)
    else $error("out-of-range query entered the pipeline");

endmodule
`default_nettype wire
